[design/okdc_pkg.sv]
// shared types, constants and keystream function for the key decode checker
package okdc_pkg;

  localparam int unsigned KeyBytes = 11;
  localparam int unsigned SumBytes = 9;
  localparam int unsigned CountW   = 4;

  localparam logic [15:0] SumInit      = 16'h5555;
  localparam logic [7:0]  HeaderByte   = 8'h24;
  localparam logic [7:0]  NibbleFirst  = 8'h41;
  localparam logic [7:0]  NibbleLast   = 8'h50;
  localparam logic [31:0] ProductReset = 32'd0;
  localparam logic [15:0] YearReset    = 16'd2021;
  localparam logic [3:0]  MonthReset   = 4'd1;

  typedef enum logic [1:0] {
    REG_PRODUCT = 2'd0,
    REG_YEAR    = 2'd1,
    REG_MONTH   = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VERDICT_INVALID = 2'd0,
    VERDICT_EXPIRED = 2'd1,
    VERDICT_VALID   = 2'd2
  } verdict_e;

  // decoded key bytes and checksum as they stand after the current character
  typedef struct packed {
    logic [KeyBytes-1:0][7:0] bytes;
    logic [15:0]              sum;
  } key_t;

  // keystream byte for key position n
  function automatic logic [7:0] stream_byte(input logic [CountW-1:0] n);
    logic [15:0] k;
    k = ({12'd0, n} ^ (16'h0055 << n[2:0])) + ({12'd0, n} * 16'd13);
    return k[15:8] ^ k[7:0];
  endfunction

endpackage

[design/okdc_decode.sv]
// character decode: nibble merge, keystream xor, byte store and checksum
module okdc_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        char_i,
  input  logic              last_i,
  output okdc_pkg::key_t    key_o
);
  import okdc_pkg::*;

  logic [KeyBytes-1:0][7:0] bytes_q, bytes_d;
  logic [CountW-1:0]        cnt_q, cnt_d;
  logic                     pend_q, pend_d;
  logic [3:0]               high_q, high_d;
  logic [15:0]              sum_q, sum_d;
  logic                     is_nib;
  logic [7:0]               nib_full;
  logic [7:0]               b;
  logic [15:0]              b_w;

  assign nib_full = char_i - NibbleFirst;
  assign is_nib   = (char_i >= NibbleFirst) && (char_i <= NibbleLast)
                    && (cnt_q < CountW'(KeyBytes));
  assign b        = {high_q, nib_full[3:0]} ^ stream_byte(cnt_q);
  assign b_w      = {8'd0, b};

  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    high_d  = high_q;
    sum_d   = sum_q;
    if (is_nib) begin
      if (!pend_q) begin
        high_d = nib_full[3:0];
        pend_d = 1'b1;
      end else begin
        pend_d         = 1'b0;
        bytes_d[cnt_q] = b;
        if (cnt_q < CountW'(SumBytes)) begin
          sum_d = ((sum_q ^ b_w) + b_w) ^ (b_w << cnt_q);
        end
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  assign key_o.bytes = bytes_d;
  assign key_o.sum   = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      high_q  <= '0;
      sum_q   <= SumInit;
    end else if (step_i) begin
      if (last_i) begin
        bytes_q <= '0;
        cnt_q   <= '0;
        pend_q  <= 1'b0;
        high_q  <= '0;
        sum_q   <= SumInit;
      end else begin
        bytes_q <= bytes_d;
        cnt_q   <= cnt_d;
        pend_q  <= pend_d;
        high_q  <= high_d;
        sum_q   <= sum_d;
      end
    end
  end

endmodule

[design/okdc_judge.sv]
// verdict logic over the decoded key fields
module okdc_judge (
  input  okdc_pkg::key_t     key_i,
  input  logic [31:0]        product_i,
  input  logic [15:0]        year_i,
  input  logic [3:0]         month_i,
  output okdc_pkg::verdict_e verdict_o
);
  import okdc_pkg::*;

  logic [15:0] month;
  logic [15:0] year;
  logic [31:0] prod;
  logic [15:0] check;

  assign month = {key_i.bytes[2], key_i.bytes[1]};
  assign year  = {key_i.bytes[4], key_i.bytes[3]};
  assign prod  = {key_i.bytes[8], key_i.bytes[7], key_i.bytes[6], key_i.bytes[5]};
  assign check = {key_i.bytes[10], key_i.bytes[9]};

  always_comb begin
    priority if (key_i.bytes[0] != HeaderByte) begin
      verdict_o = VERDICT_INVALID;
    end else if (check != key_i.sum) begin
      verdict_o = VERDICT_INVALID;
    end else if (prod != product_i) begin
      verdict_o = VERDICT_INVALID;
    end else if (year < year_i) begin
      verdict_o = VERDICT_EXPIRED;
    end else if ((year == year_i) && (month < {12'd0, month_i})) begin
      verdict_o = VERDICT_EXPIRED;
    end else begin
      verdict_o = VERDICT_VALID;
    end
  end

endmodule

[design/obfuscated_key_decode_check.sv]
// top level: input register, decode and verdict, result register, config registers
// latency: a character transfer is registered in the input register, then decoded from there as it steps on;
//   on the final character that step loads the verdict into the result register
// throughput: one character per cycle unless a final character waits on a full result register
// s_axis_tready stays high while a verdict waits, unless the held character is itself final
// reset: asynchronous active low; clears the key state, checksum seed 0x5555,
//   config to product 0, year 2021, month 1
module obfuscated_key_decode_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // last_char
  // verdict stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [1:0] verdict, [7:2] zero
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);
  import okdc_pkg::*;

  // configuration registers
  logic [31:0] product_q;
  logic [15:0] year_q;
  logic [3:0]  month_q;

  // input register
  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        last_q;

  // result register
  logic        out_valid_q;
  verdict_e    verdict_q;

  logic        step;
  logic        s_fire;
  key_t        key;
  verdict_e    verdict;

  // the held character can move on unless it is final and the result slot stays full
  assign step          = in_valid_q && (!last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      product_q <= ProductReset;
      year_q    <= YearReset;
      month_q   <= MonthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PRODUCT: product_q <= cfg_wdata_i;
        REG_YEAR:    year_q    <= cfg_wdata_i[15:0];
        REG_MONTH:   month_q   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload of the input register
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      char_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  okdc_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (char_q),
    .last_i (last_q),
    .key_o  (key)
  );

  okdc_judge u_judge (
    .key_i     (key),
    .product_i (product_q),
    .year_i    (year_q),
    .month_i   (month_q),
    .verdict_o (verdict)
  );

  // result register: loaded by a final character, emptied by the downstream transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      verdict_q   <= VERDICT_INVALID;
    end else if (step && last_q) begin
      out_valid_q <= 1'b1;
      verdict_q   <= verdict;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, verdict_q};

  // a final character that gets processed always yields a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && last_q) |=> m_axis_tvalid)
    else $error("final character produced no verdict");

  // an empty input register always takes a new character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled while empty");

  // a held final character must wait while the pending verdict is not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && last_q && m_axis_tvalid && !m_axis_tready) |-> (!step && !s_axis_tready))
    else $error("verdict overwritten before transfer");

  // a verdict never carries the unused code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("verdict code out of range");

endmodule

[tb/testbench.sv]
// self-checking testbench for obfuscated_key_decode_check: streams license keys and checks verdicts
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import okdc_pkg::*;

  // one key character as queued for the driver
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } key_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] char_code
  logic        s_axis_tlast = 1'b0;   // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;          // [1:0] verdict, [7:2] zero
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = 2'd0;
  logic [31:0] cfg_wdata_i = 32'd0;

  obfuscated_key_decode_check DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // characters waiting for the driver, and verdicts the block still owes us
  key_char_t key_chars[$];
  key_char_t stage_q[$];
  verdict_e  due_verdicts[$];
  key_char_t next_char;

  // mirror of the configuration registers
  logic [31:0] want_product = ProductReset;
  logic [15:0] year_now     = YearReset;
  logic [3:0]  month_now    = MonthReset;

  // mirror of the decode state
  logic [7:0]  key_bytes [KeyBytes];
  logic [3:0]  n_bytes;
  logic        half_seen;
  logic [3:0]  hi_nib;
  logic [15:0] csum;

  // traffic shaping knobs
  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 71;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  // bookkeeping
  int unsigned errors = 0;
  int unsigned n_chars = 0;
  int unsigned n_queued = 0;
  int unsigned n_keys = 0;
  int unsigned n_valid = 0;
  int unsigned n_expired = 0;
  int unsigned n_invalid = 0;
  int unsigned n_in_stall = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // position-dependent obfuscation byte
  function automatic logic [7:0] keystream(input logic [3:0] pos);
    int unsigned n;
    int unsigned k;
    n = pos;
    k = (n ^ (32'h55 << (n & 7))) + n * 13;
    return 8'((k >> 8) ^ k);
  endfunction

  // one step of the 16-bit running checksum
  function automatic logic [15:0] sum_step(input logic [15:0] s, input logic [7:0] p,
                                           input logic [3:0] pos);
    logic [31:0] t;
    t = (({16'd0, s} ^ {24'd0, p}) + {24'd0, p}) ^ ({24'd0, p} << pos);
    return t[15:0];
  endfunction

  function automatic void clear_key();
    foreach (key_bytes[i]) key_bytes[i] = 8'd0;
    n_bytes   = 4'd0;
    half_seen = 1'b0;
    hi_nib    = 4'd0;
    csum      = SumInit;
  endfunction

  // header, checksum and product gate acceptance; then the date decides expiry
  function automatic verdict_e judge_key();
    logic [15:0] month;
    logic [15:0] year;
    logic [15:0] chk;
    logic [31:0] prod;
    month = {key_bytes[2], key_bytes[1]};
    year  = {key_bytes[4], key_bytes[3]};
    prod  = {key_bytes[8], key_bytes[7], key_bytes[6], key_bytes[5]};
    chk   = {key_bytes[10], key_bytes[9]};
    if (key_bytes[0] != HeaderByte || chk != csum || prod != want_product)
      return VERDICT_INVALID;
    if (year < year_now || (year == year_now && month < {12'd0, month_now}))
      return VERDICT_EXPIRED;
    return VERDICT_VALID;
  endfunction

  // apply one accepted character; the final one is decoded before the verdict
  function automatic void decode_char(input logic [7:0] code, input logic fin);
    logic [7:0] b;
    logic [3:0] nib;
    if (code >= NibbleFirst && code <= NibbleLast && n_bytes < KeyBytes) begin
      nib = 4'(code - NibbleFirst);
      if (!half_seen) begin
        hi_nib    = nib;
        half_seen = 1'b1;
      end else begin
        half_seen = 1'b0;
        b = {hi_nib, nib} ^ keystream(n_bytes);
        key_bytes[n_bytes] = b;
        if (n_bytes < SumBytes) csum = sum_step(csum, b, n_bytes);
        n_bytes = n_bytes + 4'd1;
      end
    end
    if (fin) begin
      due_verdicts.push_back(judge_key());
      clear_key();
    end
  endfunction

  initial clear_key();

  // ---------------------------------------------------------------------------
  // driver: feeds key_chars, predicts on every accepted transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_char(s_axis_tdata, s_axis_tlast);
        n_chars++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (key_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_char = key_chars.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_char.code;
          s_axis_tlast  <= next_char.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end else begin
        // input is backpressured
        n_in_stall++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver ready: random stalls plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each verdict transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endfunction

  always @(posedge clk_i) begin
    verdict_e want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_verdicts.size() == 0) begin
        note_error($sformatf("unexpected verdict transfer, tdata 0x%02h", m_axis_tdata));
      end else begin
        want = due_verdicts.pop_front();
        if (m_axis_tdata[1:0] !== want)
          note_error($sformatf("verdict expected %0d got %0d", want, m_axis_tdata[1:0]));
        if (m_axis_tdata[7:2] !== 6'd0)
          note_error($sformatf("pad bits expected 0 got 0x%02h", m_axis_tdata[7:2]));
        case (want)
          VERDICT_VALID:   n_valid++;
          VERDICT_EXPIRED: n_expired++;
          default:         n_invalid++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // any code outside the nibble range
  function automatic logic [7:0] noise_code();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c >= NibbleFirst && c <= NibbleLast);
    return c;
  endfunction

  function automatic logic [7:0] mixed_code();
    if ($urandom_range(99) < 60) return 8'(NibbleFirst + $urandom_range(15));
    return noise_code();
  endfunction

  function automatic void stage_char(input logic [7:0] code);
    key_char_t kc;
    kc.code = code;
    kc.last = 1'b0;
    stage_q.push_back(kc);
  endfunction

  // obfuscate one decoded byte into two nibble characters, sprinkled with noise
  function automatic void stage_byte(input logic [7:0] val, input int unsigned pos);
    logic [7:0] plain;
    plain = val ^ keystream(4'(pos));
    if ($urandom_range(99) < 12) stage_char(noise_code());
    stage_char(8'(NibbleFirst + plain[7:4]));
    if ($urandom_range(99) < 12) stage_char(noise_code());
    stage_char(8'(NibbleFirst + plain[3:0]));
  endfunction

  // mark the end of the key, either on its last character or on a trailing one
  function automatic void close_key();
    key_char_t kc;
    if (stage_q.size() == 0 || $urandom_range(1) == 0) begin
      kc.code = ($urandom_range(3) == 0) ? 8'h00 : noise_code();
      kc.last = 1'b1;
      stage_q.push_back(kc);
    end else begin
      stage_q[stage_q.size() - 1].last = 1'b1;
    end
    foreach (stage_q[i]) key_chars.push_back(stage_q[i]);
    n_queued += stage_q.size();
    n_keys++;
    stage_q.delete();
  endfunction

  // mostly well-formed keys with random dates; some corrupted, cut short,
  // overlong or plain garbage
  function automatic void add_random_key();
    logic [7:0]  dec [KeyBytes];
    logic [15:0] yr;
    logic [15:0] mo;
    logic [15:0] s;
    logic [31:0] prod;
    int unsigned pick;
    int unsigned flaw;
    int unsigned keep;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick >= 90) begin
      len = $urandom_range(1, 30);
      repeat (len) stage_char(mixed_code());
      close_key();
      return;
    end
    case ($urandom_range(3))
      0: yr = year_now;
      1: yr = year_now - 16'd1;
      2: yr = year_now + 16'd1;
      default: yr = 16'($urandom);
    endcase
    mo = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(15));
    prod = want_product;
    flaw = (pick >= 55 && pick < 70) ? $urandom_range(1, 3) : 0;
    dec[0] = HeaderByte;
    if (flaw == 1) dec[0] = HeaderByte ^ 8'($urandom_range(1, 255));
    if (flaw == 2) prod = prod ^ (32'd1 << $urandom_range(31));
    {dec[2], dec[1]} = mo;
    {dec[4], dec[3]} = yr;
    {dec[8], dec[7], dec[6], dec[5]} = prod;
    s = SumInit;
    for (int i = 0; i < SumBytes; i++) s = sum_step(s, dec[i], 4'(i));
    if (flaw == 3) s = s ^ 16'($urandom_range(1, 65535));
    {dec[10], dec[9]} = s;
    keep = (pick >= 78) ? $urandom_range(0, KeyBytes - 1) : KeyBytes;
    for (int i = 0; i < keep; i++) stage_byte(dec[i], i);
    // odd nibble count: the lone high nibble must be dropped
    if (pick >= 78 && $urandom_range(1) == 1) stage_char(8'(NibbleFirst + $urandom_range(15)));
    // overlong: everything past the eleventh byte is ignored
    if (pick >= 70 && pick < 78) begin
      len = $urandom_range(1, 8);
      repeat (len) stage_char(mixed_code());
    end
    close_key();
  endfunction

  task automatic cfg_write(input cfg_reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // register settings per round, extremes first
  task automatic load_setting(input int r);
    logic [31:0] prod;
    logic [15:0] yr;
    logic [3:0]  mo;
    case (r)
      1: begin prod = 32'hFFFF_FFFF; yr = 16'hFFFF; mo = 4'd15; end
      2: begin prod = $urandom; yr = 16'd0; mo = 4'd0; end
      3: begin prod = $urandom; yr = 16'($urandom_range(1990, 2100)); mo = 4'd12; end
      4: begin prod = 32'd0; yr = 16'($urandom); mo = 4'd1; end
      default: begin prod = $urandom; yr = 16'($urandom); mo = 4'($urandom_range(15)); end
    endcase
    cfg_write(REG_PRODUCT, prod);
    want_product = prod;
    cfg_write(REG_YEAR, {16'd0, yr});
    year_now = yr;
    cfg_write(REG_MONTH, {28'd0, mo});
    month_now = mo;
  endtask

  // block is idle once every queued character went in and every verdict came out
  task automatic drain_block();
    while (key_chars.size() != 0 || s_axis_tvalid || due_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned target;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < 6; r++) begin
      if (r > 0) begin
        drain_block();
        load_setting(r);
      end
      // receiver-heavy idling, then sender-heavy, then none
      send_idle_pct <= (r < 2) ? 28 : (r < 4) ? 71 : 0;
      recv_idle_pct <= (r < 2) ? 71 : (r < 4) ? 28 : 0;

      if (r == 0) begin
        // empty key: a lone final NUL
        stage_char(8'h00); stage_q[0].last = 1'b1;
        foreach (stage_q[i]) key_chars.push_back(stage_q[i]);
        n_queued += stage_q.size(); n_keys++; stage_q.delete();
        // a lone high nibble as the whole key
        stage_char(NibbleFirst); stage_q[0].last = 1'b1;
        foreach (stage_q[i]) key_chars.push_back(stage_q[i]);
        n_queued += stage_q.size(); n_keys++; stage_q.delete();
        // codes just outside the nibble range, then the range ends
        stage_char(8'h40); stage_char(8'h51); stage_char(8'hFF);
        stage_char(NibbleLast); stage_char(NibbleFirst);
        stage_q[stage_q.size() - 1].last = 1'b1;
        foreach (stage_q[i]) key_chars.push_back(stage_q[i]);
        n_queued += stage_q.size(); n_keys++; stage_q.delete();
      end

      if (r == 4) begin
        // long receiver hold-off with a burst of short keys behind it
        hold_go <= 1'b1;
        repeat (20) begin
          stage_char(8'h00);
          stage_q[0].last = 1'b1;
          key_chars.push_back(stage_q[0]);
          n_queued++; n_keys++;
          stage_q.delete();
        end
      end

      target = n_queued + 280;
      while (n_queued < target) add_random_key();
    end

    drain_block();
    $display("run covered %0d key characters in %0d keys over 6 register settings",
             n_chars, n_keys);
    $display("verdicts: %0d valid, %0d expired, %0d invalid; %0d input stall cycles",
             n_valid, n_expired, n_invalid, n_in_stall);
    if (errors == 0) begin
      $display("obfuscated_key_decode_check verification clean");
    end else begin
      $display("obfuscated_key_decode_check verification failed");
    end
    $finish;
  end

  // hard limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("obfuscated_key_decode_check verification failed");
    $finish;
  end

endmodule

[obfuscated_key_decode_check.f]
design/okdc_pkg.sv
design/okdc_decode.sv
design/okdc_judge.sv
design/obfuscated_key_decode_check.sv
tb/testbench.sv
